/* rtl/ntps_pkg.sv */
// shared types and constants for the neighbor table parent select block
`default_nettype none

package ntps_pkg;

  // default number of neighbor slots
  localparam int unsigned TableDepthDef = 16;

  // hop value that means "no parent"
  localparam logic [15:0] NO_HOP = 16'hFFFF;

  typedef enum logic {
    OP_BEACON = 1'b0,
    OP_SELECT = 1'b1
  } ntps_op_e;

  // input transaction
  typedef struct packed {
    logic              opcode;
    logic [7:0]        neighbor_id;
    logic signed [7:0] signal_strength;
    logic [15:0]       hop_distance;
  } ntps_in_t;

  // result transaction
  typedef struct packed {
    logic        forward_valid;
    logic [15:0] forward_hop;
    logic        entry_added;
    logic        entry_updated;
    logic [7:0]  chosen_parent;
    logic [15:0] chosen_parent_hop;
  } ntps_out_t;

  // token that walks the cell chain
  typedef struct packed {
    logic              vld;
    logic              op;
    logic [7:0]        id;
    logic signed [7:0] strength;
    logic [15:0]       hop;
    logic              hit;
    logic              placed;
    logic              have;
    logic [15:0]       best_hop;
    logic [7:0]        best_id;
    logic signed [7:0] best_str;
  } ntps_tok_t;

endpackage

`default_nettype wire

/* rtl/ntps_cell.sv */
// one neighbor slot: holds an entry and passes the walking token on
`default_nettype none

module ntps_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              occ_i,
  input  wire logic              slot_i,
  input  wire ntps_pkg::ntps_tok_t tok_i,
  output ntps_pkg::ntps_tok_t    tok_o
);
  import ntps_pkg::*;

  logic [7:0]        id_q;
  logic signed [7:0] str_q;
  logic [7:0]        cnt_q;
  logic [15:0]       hop_q;

  logic      upd, ins, sel, win;
  ntps_tok_t tok_d, tok_q;

  // match, insert and best-candidate decisions for this slot
  always_comb begin
    upd = tok_i.vld && (tok_i.op == OP_BEACON) && occ_i && !tok_i.hit &&
          (id_q == tok_i.id);
    ins = tok_i.vld && (tok_i.op == OP_BEACON) && slot_i && !tok_i.hit;
    sel = tok_i.vld && (tok_i.op == OP_SELECT) && occ_i && (hop_q != NO_HOP);
    win = !tok_i.have || (hop_q < tok_i.best_hop) ||
          ((hop_q == tok_i.best_hop) && (str_q > tok_i.best_str));
    tok_d = tok_i;
    if (upd) begin
      tok_d.hit = 1'b1;
    end
    if (ins) begin
      tok_d.placed = 1'b1;
    end
    if (sel && win) begin
      tok_d.have     = 1'b1;
      tok_d.best_hop = hop_q;
      tok_d.best_id  = id_q;
      tok_d.best_str = str_q;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (upd) begin
      str_q <= tok_i.strength;
      hop_q <= tok_i.hop;
      cnt_q <= cnt_q + 8'd1;
    end else if (ins) begin
      id_q  <= tok_i.id;
      str_q <= tok_i.strength;
      hop_q <= tok_i.hop;
      cnt_q <= 8'd1;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

/* rtl/neighbor_table_parent_select.sv */
// top level: neighbor table as a chain of slot cells with parent selection
//
// Each transaction (beacon or select) is accepted when start_i is high and
// busy_o is low. A token then walks the row of TABLE_DEPTH slot cells, one
// cell per clock. The result appears on res_o with a one-cycle res_valid_o
// strobe once the token has left the last cell. busy_o drops in that same
// strobe cycle, so the next transaction can be taken at the edge that ends
// it; no new transaction is taken while one walks the chain. The result
// cannot be held off: it must be captured in the strobe cycle. cfg_we_i
// writes the is_root bit and should only be used while busy_o is low.
`default_nettype none

module neighbor_table_parent_select #(
  parameter int unsigned TABLE_DEPTH = ntps_pkg::TableDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire ntps_pkg::ntps_in_t in_i,
  output logic                  busy_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  output logic                  res_valid_o,
  output ntps_pkg::ntps_out_t   res_o
);
  import ntps_pkg::*;

  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);

  logic          busy_q, busy_d;
  logic          root_q;
  logic [UW-1:0] used_q, used_d;
  logic [7:0]    par_id_q, par_id_d;
  logic [15:0]   par_hop_q, par_hop_d;
  logic          res_vld_q;
  ntps_out_t     res_q, res_d;
  logic          accept;

  ntps_tok_t              tok [TABLE_DEPTH+1];
  ntps_tok_t              launch;
  logic [TABLE_DEPTH-1:0] occ, slot;
  ntps_tok_t              tail;

  assign accept = start_i && !busy_q;

  // launch token built from the accepted transaction
  always_comb begin
    launch          = '0;
    launch.vld      = accept;
    launch.op       = in_i.opcode;
    launch.id       = in_i.neighbor_id;
    launch.strength = in_i.signal_strength;
    launch.hop      = in_i.hop_distance;
  end

  assign tok[0] = launch;

  // slot cells
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    assign occ[k]  = UW'(k) < used_q;
    assign slot[k] = UW'(k) == used_q;
    ntps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .occ_i  (occ[k]),
      .slot_i (slot[k]),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign tail = tok[TABLE_DEPTH];

  // finish the transaction when the token leaves the chain
  always_comb begin
    busy_d    = busy_q;
    used_d    = used_q;
    par_id_d  = par_id_q;
    par_hop_d = par_hop_q;
    res_d     = '0;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tail.vld) begin
      busy_d = 1'b0;
      if (tail.op == OP_BEACON) begin
        res_d.entry_updated = tail.hit;
        res_d.entry_added   = tail.placed;
        if (tail.placed) begin
          used_d = used_q + UW'(1);
        end
        if (!tail.hit && !root_q) begin
          res_d.forward_valid = 1'b1;
          res_d.forward_hop   = tail.hop + 16'd1;
        end
      end else if (root_q) begin
        par_id_d  = 8'd0;
        par_hop_d = 16'd0;
      end else if (tail.have) begin
        par_id_d  = tail.best_id;
        par_hop_d = tail.best_hop;
      end else begin
        par_id_d  = 8'd0;
        par_hop_d = NO_HOP;
      end
    end
    res_d.chosen_parent     = par_id_d;
    res_d.chosen_parent_hop = par_hop_d;
  end

  // control and table-level state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      root_q    <= 1'b0;
      used_q    <= '0;
      par_id_q  <= 8'd0;
      par_hop_q <= NO_HOP;
      res_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      used_q    <= used_d;
      par_id_q  <= par_id_d;
      par_hop_q <= par_hop_d;
      res_vld_q <= tail.vld;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (tail.vld) begin
      res_q <= res_d;
    end
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/ntps_checker.sv */
// port-level checks for the neighbor table parent select block
`default_nettype none

module ntps_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               res_valid_o,
  input wire ntps_pkg::ntps_out_t res_o
);
  import ntps_pkg::*;

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // a result only ends a transaction in flight
  a_res_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result without transaction in flight");

  // one strobe per transaction
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // a refreshed entry is never also added and never forwarded
  a_update_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.entry_updated) |->
      (!res_o.entry_added && !res_o.forward_valid))
    else $error("updated entry also added or forwarded");

endmodule

bind neighbor_table_parent_select ntps_checker u_ntps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire

/* tb/sv/ntps_scoreboard_pkg.sv */
// scoreboard class that mirrors the neighbor table and checks each result
`timescale 1ns / 1ps

package ntps_scoreboard_pkg;
  import ntps_pkg::*;

  localparam int unsigned Slots = TableDepthDef;

  class neighbor_table_sb;
    // mirrored table contents and parent choice
    logic [7:0]        slot_id   [Slots];
    logic signed [7:0] slot_rssi [Slots];
    logic [7:0]        slot_cnt  [Slots];
    logic [15:0]       slot_hop  [Slots];
    int unsigned       slots_used;
    logic [7:0]        chosen_node;
    logic [15:0]       chosen_dist;
    bit                root_mode;
    ntps_out_t         expected_replies[$];
    int unsigned       mismatch_cnt;

    function new();
      slots_used   = 0;
      chosen_node  = '0;
      chosen_dist  = NO_HOP;
      root_mode    = 1'b0;
      mismatch_cnt = 0;
    endfunction

    function void set_root(bit v);
      root_mode = v;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // an id already in the table (random while it is empty), so that beacons refresh entries
    function logic [7:0] known_id();
      if (slots_used == 0) return 8'($urandom());
      return slot_id[$urandom_range(0, slots_used - 1)];
    endfunction

    function string show(ntps_out_t r);
      return $sformatf("fwd=%0b hop=%04h add=%0b upd=%0b parent=%02h phop=%04h",
                       r.forward_valid, r.forward_hop, r.entry_added,
                       r.entry_updated, r.chosen_parent, r.chosen_parent_hop);
    endfunction

    function void flag_mismatch(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
    endfunction

    // update the mirrored table for one accepted transaction, queue its result
    function void record_request(ntps_in_t req);
      ntps_out_t         rep;
      int                hit_idx;
      bit                have;
      logic signed [7:0] best_rssi;
      rep = '0;
      if (req.opcode == OP_SELECT) begin
        chosen_node = '0;
        if (root_mode) begin
          chosen_dist = '0;
        end else begin
          // smallest hop wins, strictly higher rssi breaks a tie
          chosen_dist = NO_HOP;
          have        = 1'b0;
          best_rssi   = '0;
          for (int i = 0; i < slots_used; i++) begin
            if (slot_hop[i] == NO_HOP) continue;
            if (!have || slot_hop[i] < chosen_dist ||
                (slot_hop[i] == chosen_dist && slot_rssi[i] > best_rssi)) begin
              have        = 1'b1;
              chosen_dist = slot_hop[i];
              chosen_node = slot_id[i];
              best_rssi   = slot_rssi[i];
            end
          end
        end
      end else begin
        // beacon: refresh on a hit, otherwise insert if there is room and forward unless root
        hit_idx = -1;
        for (int i = 0; i < slots_used; i++) begin
          if (hit_idx < 0 && slot_id[i] == req.neighbor_id) hit_idx = i;
        end
        if (hit_idx >= 0) begin
          slot_rssi[hit_idx] = req.signal_strength;
          slot_hop[hit_idx]  = req.hop_distance;
          slot_cnt[hit_idx]  = slot_cnt[hit_idx] + 8'd1;
          rep.entry_updated  = 1'b1;
        end else begin
          if (slots_used < Slots) begin
            slot_id[slots_used]   = req.neighbor_id;
            slot_rssi[slots_used] = req.signal_strength;
            slot_hop[slots_used]  = req.hop_distance;
            slot_cnt[slots_used]  = 8'd1;
            slots_used++;
            rep.entry_added = 1'b1;
          end
          if (!root_mode) begin
            rep.forward_valid = 1'b1;
            rep.forward_hop   = req.hop_distance + 16'd1;
          end
        end
      end
      rep.chosen_parent     = chosen_node;
      rep.chosen_parent_hop = chosen_dist;
      expected_replies.push_back(rep);
    endfunction

    // compare one result with the oldest expectation
    function void check_reply(ntps_out_t got);
      ntps_out_t want;
      string     bad;
      if (expected_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %s", show(got)));
        return;
      end
      want = expected_replies.pop_front();
      bad  = "";
      if (got.forward_valid !== want.forward_valid) bad = {bad, " forward_valid"};
      if (got.forward_hop !== want.forward_hop) bad = {bad, " forward_hop"};
      if (got.entry_added !== want.entry_added) bad = {bad, " entry_added"};
      if (got.entry_updated !== want.entry_updated) bad = {bad, " entry_updated"};
      if (got.chosen_parent !== want.chosen_parent) bad = {bad, " chosen_parent"};
      if (got.chosen_parent_hop !== want.chosen_parent_hop) bad = {bad, " chosen_parent_hop"};
      if (bad != "") begin
        flag_mismatch($sformatf("%s differ: expected %s, actual %s",
                                bad, show(want), show(got)));
      end
    endfunction

    // results still owed at the end of the run
    function void flush_missing();
      if (expected_replies.size() != 0) begin
        flag_mismatch($sformatf("%0d results never arrived, oldest %s",
                                expected_replies.size(), show(expected_replies[0])));
        mismatch_cnt += expected_replies.size() - 1;
        expected_replies.delete();
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_neighbor_table_parent_select.sv */
// top of the neighbor table parent select testbench: clock, stimulus, checks
`timescale 1ns / 1ps

module tb_neighbor_table_parent_select;
  import ntps_pkg::*;
  import ntps_scoreboard_pkg::*;

  localparam int unsigned Latency    = TableDepthDef + 1;
  localparam int unsigned StallLimit = 1000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start_i     = 1'b0;
  ntps_in_t         in_i        = '0;
  logic             busy_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             res_valid_o;
  ntps_out_t        res_o;
  int unsigned      quiet_cycles = 0;
  neighbor_table_sb sb = new();

  neighbor_table_parent_select dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // result transactions are taken in their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_reply(res_o);
  end

  // watchdog on cycles without any accepted transaction or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[neighbor_table_parent_select] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one transaction and hold it until accepted
  task automatic send_item(input ntps_in_t req);
    start_i <= 1'b1;
    in_i    <= req;
    do @(posedge clk_i); while (busy_o);
    sb.record_request(req);
  endtask

  // sender gap with junk on the data lines
  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    in_i    <= ntps_in_t'($urandom());
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_root(input bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_root(v);
  endtask

  function automatic ntps_in_t beacon(input logic [7:0] id, input logic [7:0] rssi,
                                      input logic [15:0] hop);
    ntps_in_t req;
    req.opcode          = OP_BEACON;
    req.neighbor_id     = id;
    req.signal_strength = rssi;
    req.hop_distance    = hop;
    return req;
  endfunction

  // select with junk in the unused fields
  function automatic ntps_in_t select_req();
    ntps_in_t req;
    req        = ntps_in_t'($urandom());
    req.opcode = OP_SELECT;
    return req;
  endfunction

  // mostly refreshes of known neighbors, small hops so ties come up
  function automatic ntps_in_t random_req();
    ntps_in_t req;
    req.opcode      = ($urandom_range(0, 99) < 20) ? OP_SELECT : OP_BEACON;
    req.neighbor_id = ($urandom_range(0, 99) < 70) ? sb.known_id() : 8'($urandom());
    case ($urandom_range(0, 3))
      0:       req.signal_strength = 8'($urandom_range(0, 2) - 1);
      1:       req.signal_strength = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      default: req.signal_strength = 8'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: req.hop_distance = 16'($urandom_range(0, 6));
      6:                req.hop_distance = 16'hFFFF;
      7:                req.hop_distance = 16'hFFFE;
      default:          req.hop_distance = 16'($urandom());
    endcase
    return req;
  endfunction

  // random transactions; idle density changes every 25 of them
  task automatic run_random(input int unsigned count, input bit allow_idle);
    int unsigned idle_pct;
    idle_pct = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 25;
          default: idle_pct = 60;
        endcase
        if (!allow_idle) idle_pct = 0;
      end
      send_item(random_req());
      if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 6));
      else if (allow_idle && $urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_root(1'b0);

    // empty table, then an entry whose hop means no parent
    send_item(select_req());
    send_item(beacon(8'h00, 8'h80, 16'hFFFF));
    send_item(select_req());
    // a new neighbor and its refresh, then hop ties
    send_item(beacon(8'hFF, 8'h7F, 16'h0000));
    send_item(beacon(8'hFF, 8'hFF, 16'd3));
    send_item(beacon(8'h5A, 8'h05, 16'd3));
    send_item(beacon(8'hA5, 8'h05, 16'd3));
    send_item(select_req());
    send_item(beacon(8'h33, 8'h80, 16'd2));
    send_item(select_req());

    // root node: stores but never forwards, reports itself as parent
    drain();
    write_root(1'b1);
    send_item(beacon(8'h77, 8'h10, 16'd1));
    send_item(beacon(8'hFF, 8'h20, 16'd1));
    send_item(select_req());
    drain();
    write_root(1'b0);

    // fill the table, then a new neighbor with no room left
    for (int k = 0; k < 10; k++) begin
      send_item(beacon(8'(8'h40 + k), 8'($urandom()), 16'($urandom_range(1, 10))));
    end
    send_item(beacon(8'hC8, 8'h00, 16'd7));
    send_item(select_req());

    run_random(200, 1'b1);
    drain();
    write_root(1'b1);
    run_random(80, 1'b1);
    drain();
    write_root(1'b0);
    run_random(110, 1'b1);
    run_random(60, 1'b0);

    drain();
    repeat (Latency + 3) @(posedge clk_i);
    sb.flush_missing();
    if (sb.mismatch_cnt == 0) begin
      $display("[neighbor_table_parent_select] OK");
    end else begin
      $display("[neighbor_table_parent_select] ERROR");
    end
    $finish;
  end

endmodule
